/* design/rv64im_integer_execute_core_assert.svh */
// Assertion macros for the integer execute core.
`ifndef RV64IM_INTEGER_EXECUTE_CORE_ASSERT_SVH
`define RV64IM_INTEGER_EXECUTE_CORE_ASSERT_SVH
// Immediate implication checked on every clock unless reset.
`define RVX_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked on every clock unless reset.
`define RVX_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

/* design/rvx_pkg.sv */
// Shared types, operation codes and constants of the integer execute core.
package rvx_pkg;
   localparam int unsigned XLEN_DEFAULT = 64;
   localparam int unsigned REG_COUNT = 31;
   localparam int unsigned EXC_NONE = 0;
   localparam int unsigned EXC_ILLEGAL = 1;
   localparam int unsigned EXC_ECALL = 2;

   typedef enum logic [5:0] {
      OP_ILLEGAL = 6'd0, OP_ECALL, OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_CJAL, OP_CJALR,
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU, OP_CBEQ, OP_CBNE,
      OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
      OP_OR, OP_AND, OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
      OP_SLLI, OP_SRLI, OP_SRAI, OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW, OP_ADDW,
      OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW, OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
      OP_DIV, OP_DIVU, OP_REM, OP_REMU, OP_MULW, OP_DIVW, OP_DIVUW, OP_REMW,
      OP_REMUW, OP_NOP, OP_R58, OP_R59, OP_R60, OP_R61, OP_R62, OP_R63
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;   // latch the request fields
      logic read;      // latch the source operands
      logic exec;      // form the single-cycle result
      logic mul_start;
      logic mul_step;
      logic mul_fin;
      logic div_start;
      logic div_step;
      logic div_fin;
      logic commit;    // write back and load the output register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic mul_last;
      logic div_last;
   } status_type;
endpackage

/* design/rvx_datapath.sv */
// Datapath: register file, ALU, sequential multiplier and divider, result register.
module rvx_datapath #(
   parameter int unsigned XLEN = rvx_pkg::XLEN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  rvx_pkg::cmd_type    cmd,
   output rvx_pkg::status_type status,
   input  logic [5:0]          req_op,
   input  logic [4:0]          req_rd,
   input  logic [4:0]          req_rs1,
   input  logic [4:0]          req_rs2,
   input  logic [31:0]         req_imm,
   input  logic [XLEN-1:0]     req_pc,
   output logic [143:0]        rsp_data
);
   localparam int unsigned SW = $clog2(XLEN);
   localparam int unsigned HX = XLEN / 2;
   localparam int unsigned CW = $clog2(XLEN + 1);

   logic [XLEN-1:0] rf_ff [rvx_pkg::REG_COUNT];
   logic [30:0] vld_ff, vld_in;

   rvx_pkg::op_type op_ff;
   logic [4:0] rd_ff, rs1_ff, rs2_ff;
   logic [XLEN-1:0] imm_ff, pc_ff, a_ff, b_ff;
   logic [XLEN-1:0] rd1, rd2;

   // Result register fields.
   logic wr_ff, wr_in, pcv_ff, pcv_in;
   logic [4:0] idx_ff;
   logic [XLEN-1:0] val_ff, val_in, npc_ff, npc_in;
   logic [1:0] exc_ff, exc_in;

   // Multiplier: 32x32 partial products, one per cycle.
   logic [1:0] mcnt_ff;
   logic [2*XLEN-1:0] macc_ff;
   logic [HX-1:0] mx, my;
   logic [XLEN-1:0] mprod_ff;
   logic [1:0] mcnt_d_ff;
   logic mvalid_ff;

   // Divider: restoring, one bit per cycle.
   logic [XLEN-1:0] dq_ff, dr_ff, dd_ff, dvs_ff;
   logic [CW-1:0] dcnt_ff;
   logic dnq_ff, dnr_ff, dzero_ff, dovf_ff;
   logic [XLEN:0] dtrial;
   logic [XLEN-1:0] drem_sh;

   logic is_word, is_sdiv, want_rem;
   logic [XLEN-1:0] da, db;

   always_comb begin
      rd1 = (rs1_ff == 5'd0 || !vld_ff[rs1_ff - 5'd1]) ? '0 : rf_ff[rs1_ff - 5'd1];
      rd2 = (rs2_ff == 5'd0 || !vld_ff[rs2_ff - 5'd1]) ? '0 : rf_ff[rs2_ff - 5'd1];
   end

   function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
      sx32 = {{(XLEN-32){v[31]}}, v[31:0]};
   endfunction

   assign is_word = (op_ff inside {rvx_pkg::OP_DIVW, rvx_pkg::OP_DIVUW,
                                   rvx_pkg::OP_REMW, rvx_pkg::OP_REMUW});
   assign is_sdiv = (op_ff inside {rvx_pkg::OP_DIV, rvx_pkg::OP_REM,
                                   rvx_pkg::OP_DIVW, rvx_pkg::OP_REMW});
   assign want_rem = (op_ff inside {rvx_pkg::OP_REM, rvx_pkg::OP_REMU,
                                    rvx_pkg::OP_REMW, rvx_pkg::OP_REMUW});

   always_comb begin
      if (!is_word) begin
         da = a_ff;
         db = b_ff;
      end else if (is_sdiv) begin
         da = sx32(a_ff);
         db = sx32(b_ff);
      end else begin
         da = {{(XLEN-32){1'b0}}, a_ff[31:0]};
         db = {{(XLEN-32){1'b0}}, b_ff[31:0]};
      end
   end

   assign status.is_mul = (op_ff inside {rvx_pkg::OP_MUL, rvx_pkg::OP_MULH,
                           rvx_pkg::OP_MULHSU, rvx_pkg::OP_MULHU, rvx_pkg::OP_MULW});
   assign status.is_div = (op_ff inside {[rvx_pkg::OP_DIV:rvx_pkg::OP_REMU],
                           [rvx_pkg::OP_DIVW:rvx_pkg::OP_REMUW]});
   assign status.mul_last = mvalid_ff && (mcnt_d_ff == 2'd3);
   assign status.div_last = (dcnt_ff == CW'(XLEN));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= rvx_pkg::op_type'(req_op);
         rd_ff  <= req_rd;
         rs1_ff <= req_rs1;
         rs2_ff <= req_rs2;
         imm_ff <= {{(XLEN-32){req_imm[31]}}, req_imm};
         pc_ff  <= req_pc;
      end
      if (cmd.read) begin
         a_ff <= rd1;
         b_ff <= rd2;
      end
   end

   // Partial product selection: unsigned 64x64 built from four 32x32.
   always_comb begin
      mx = mcnt_ff[0] ? a_ff[XLEN-1:HX] : a_ff[HX-1:0];
      my = mcnt_ff[1] ? b_ff[XLEN-1:HX] : b_ff[HX-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvalid_ff <= 1'b0;
      end else if (cmd.mul_start) begin
         mvalid_ff <= 1'b0;
      end else if (cmd.mul_step) begin
         mvalid_ff <= 1'b1;
      end
      if (cmd.mul_start) begin
         mcnt_ff <= 2'd0;
         macc_ff <= '0;
      end else if (cmd.mul_step) begin
         mprod_ff  <= mx * my;
         mcnt_d_ff <= mcnt_ff;
         mcnt_ff   <= mcnt_ff + 2'd1;
         if (mvalid_ff) begin
            macc_ff <= macc_ff + ({{XLEN{1'b0}}, mprod_ff} << (HX * (mcnt_d_ff[0] + mcnt_d_ff[1])));
         end
      end else if (cmd.mul_fin) begin
         macc_ff <= macc_ff + ({{XLEN{1'b0}}, mprod_ff} << (HX * (mcnt_d_ff[0] + mcnt_d_ff[1])));
      end
   end

   assign dtrial  = {drem_sh, dq_ff[XLEN-1]} - {1'b0, dvs_ff};
   assign drem_sh = dr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + CW'(1);
      end
      if (cmd.div_start) begin
         dd_ff    <= da;
         dzero_ff <= (db == '0);
         dovf_ff  <= is_sdiv && (da == {1'b1, {(XLEN-1){1'b0}}}) && (db == '1);
         dnq_ff   <= is_sdiv && (da[XLEN-1] ^ db[XLEN-1]);
         dnr_ff   <= is_sdiv && da[XLEN-1];
         dq_ff    <= (is_sdiv && da[XLEN-1]) ? -da : da;
         dvs_ff   <= (is_sdiv && db[XLEN-1]) ? -db : db;
         dr_ff    <= '0;
      end else if (cmd.div_step) begin
         if (!dtrial[XLEN]) begin
            dr_ff <= dtrial[XLEN-1:0];
            dq_ff <= {dq_ff[XLEN-2:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[XLEN-2:0], dq_ff[XLEN-1]};
            dq_ff <= {dq_ff[XLEN-2:0], 1'b0};
         end
      end
   end

   // Single-cycle ops and final result formation.
   always_comb begin
      logic [XLEN-1:0] b2, sum, diff, hi, divr;
      logic [SW-1:0] sh;
      logic [4:0] shw;
      logic taken, comp;
      logic [XLEN-1:0] fall;
      b2    = imm_ff;
      sum   = '0;
      diff  = '0;
      hi    = '0;
      divr  = '0;
      sh    = imm_ff[SW-1:0];
      shw   = imm_ff[4:0];
      taken = 1'b0;
      comp  = 1'b0;
      fall  = XLEN'(4);
      wr_in  = 1'b1;
      pcv_in = 1'b0;
      val_in = '0;
      npc_in = '0;
      exc_in = 2'(rvx_pkg::EXC_NONE);
      case (op_ff)
         rvx_pkg::OP_ECALL: begin
            wr_in = 1'b0; pcv_in = 1'b1; npc_in = pc_ff; exc_in = 2'(rvx_pkg::EXC_ECALL);
         end
         rvx_pkg::OP_LUI:   val_in = imm_ff;
         rvx_pkg::OP_AUIPC: val_in = pc_ff + imm_ff;
         rvx_pkg::OP_JAL: begin
            val_in = pc_ff + XLEN'(4); pcv_in = 1'b1; npc_in = pc_ff + imm_ff;
         end
         rvx_pkg::OP_JALR: begin
            val_in = pc_ff + XLEN'(4); pcv_in = 1'b1;
            npc_in = (a_ff + imm_ff) & ~XLEN'(1);
         end
         rvx_pkg::OP_CJAL: begin
            val_in = pc_ff + XLEN'(2); pcv_in = 1'b1; npc_in = pc_ff + imm_ff;
         end
         rvx_pkg::OP_CJALR: begin
            val_in = pc_ff + XLEN'(2); pcv_in = 1'b1;
            npc_in = (a_ff + imm_ff) & ~XLEN'(1);
         end
         rvx_pkg::OP_BEQ, rvx_pkg::OP_BNE, rvx_pkg::OP_BLT, rvx_pkg::OP_BGE,
         rvx_pkg::OP_BLTU, rvx_pkg::OP_BGEU, rvx_pkg::OP_CBEQ, rvx_pkg::OP_CBNE: begin
            case (op_ff)
               rvx_pkg::OP_BEQ, rvx_pkg::OP_CBEQ: taken = (a_ff == b_ff);
               rvx_pkg::OP_BNE, rvx_pkg::OP_CBNE: taken = (a_ff != b_ff);
               rvx_pkg::OP_BLT:  taken = ($signed(a_ff) < $signed(b_ff));
               rvx_pkg::OP_BGE:  taken = !($signed(a_ff) < $signed(b_ff));
               rvx_pkg::OP_BLTU: taken = (a_ff < b_ff);
               default:          taken = (a_ff >= b_ff);
            endcase
            if (op_ff inside {rvx_pkg::OP_CBEQ, rvx_pkg::OP_CBNE}) fall = XLEN'(2);
            wr_in = 1'b0; pcv_in = 1'b1;
            npc_in = pc_ff + (taken ? imm_ff : fall);
         end
         rvx_pkg::OP_ADD:  val_in = a_ff + b_ff;
         rvx_pkg::OP_SUB:  val_in = a_ff - b_ff;
         rvx_pkg::OP_SLL:  val_in = a_ff << b_ff[SW-1:0];
         rvx_pkg::OP_SLT:  val_in = XLEN'($signed(a_ff) < $signed(b_ff));
         rvx_pkg::OP_SLTU: val_in = XLEN'(a_ff < b_ff);
         rvx_pkg::OP_XOR:  val_in = a_ff ^ b_ff;
         rvx_pkg::OP_SRL:  val_in = a_ff >> b_ff[SW-1:0];
         rvx_pkg::OP_SRA:  val_in = $signed(a_ff) >>> b_ff[SW-1:0];
         rvx_pkg::OP_OR:   val_in = a_ff | b_ff;
         rvx_pkg::OP_AND:  val_in = a_ff & b_ff;
         rvx_pkg::OP_ADDI: val_in = a_ff + b2;
         rvx_pkg::OP_SLTI: val_in = XLEN'($signed(a_ff) < $signed(b2));
         rvx_pkg::OP_SLTIU: val_in = XLEN'(a_ff < b2);
         rvx_pkg::OP_XORI: val_in = a_ff ^ b2;
         rvx_pkg::OP_ORI:  val_in = a_ff | b2;
         rvx_pkg::OP_ANDI: val_in = a_ff & b2;
         rvx_pkg::OP_SLLI: val_in = a_ff << sh;
         rvx_pkg::OP_SRLI: val_in = a_ff >> sh;
         rvx_pkg::OP_SRAI: val_in = $signed(a_ff) >>> sh;
         rvx_pkg::OP_ADDIW: begin sum = a_ff + b2; val_in = sx32(sum); end
         rvx_pkg::OP_SLLIW: val_in = sx32(XLEN'(a_ff[31:0] << shw));
         rvx_pkg::OP_SRLIW: val_in = sx32(XLEN'(a_ff[31:0] >> shw));
         rvx_pkg::OP_SRAIW: val_in = sx32(XLEN'($signed(a_ff[31:0]) >>> shw));
         rvx_pkg::OP_ADDW: begin sum = a_ff + b_ff; val_in = sx32(sum); end
         rvx_pkg::OP_SUBW: begin diff = a_ff - b_ff; val_in = sx32(diff); end
         rvx_pkg::OP_SLLW: val_in = sx32(XLEN'(a_ff[31:0] << b_ff[4:0]));
         rvx_pkg::OP_SRLW: val_in = sx32(XLEN'(a_ff[31:0] >> b_ff[4:0]));
         rvx_pkg::OP_SRAW: val_in = sx32(XLEN'($signed(a_ff[31:0]) >>> b_ff[4:0]));
         rvx_pkg::OP_MUL:  val_in = macc_ff[XLEN-1:0];
         rvx_pkg::OP_MULW: val_in = sx32(macc_ff[XLEN-1:0]);
         rvx_pkg::OP_MULH, rvx_pkg::OP_MULHSU, rvx_pkg::OP_MULHU: begin
            // Signed corrections on the unsigned high half.
            hi = macc_ff[2*XLEN-1:XLEN];
            if (op_ff != rvx_pkg::OP_MULHU && a_ff[XLEN-1]) hi = hi - b_ff;
            if (op_ff == rvx_pkg::OP_MULH && b_ff[XLEN-1]) hi = hi - a_ff;
            val_in = hi;
         end
         rvx_pkg::OP_DIV, rvx_pkg::OP_DIVU, rvx_pkg::OP_REM, rvx_pkg::OP_REMU,
         rvx_pkg::OP_DIVW, rvx_pkg::OP_DIVUW, rvx_pkg::OP_REMW, rvx_pkg::OP_REMUW: begin
            if (dzero_ff) divr = want_rem ? dd_ff : '1;
            else if (dovf_ff) divr = want_rem ? '0 : dd_ff;
            else if (want_rem) divr = dnr_ff ? -dr_ff : dr_ff;
            else divr = dnq_ff ? -dq_ff : dq_ff;
            comp = is_word;
            val_in = comp ? sx32(divr) : divr;
         end
         rvx_pkg::OP_NOP: wr_in = 1'b0;
         default: begin
            wr_in = 1'b0; pcv_in = 1'b1; npc_in = pc_ff; exc_in = 2'(rvx_pkg::EXC_ILLEGAL);
         end
      endcase
      if (rd_ff == 5'd0) wr_in = 1'b0;
      if (!wr_in) val_in = '0;
      if (!pcv_in) npc_in = '0;
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.commit && wr_in) vld_in[rd_ff - 5'd1] = 1'b1;
   end

   // The next request may be captured while this result still waits, so every
   // result field is held in its own register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (cmd.commit) begin
         if (wr_in) rf_ff[rd_ff - 5'd1] <= val_in;
         wr_ff  <= wr_in;
         idx_ff <= wr_in ? rd_ff : 5'd0;
         pcv_ff <= pcv_in;
         val_ff <= val_in;
         npc_ff <= npc_in;
         exc_ff <= exc_in;
      end
   end

   assign rsp_data = {7'd0, exc_ff, npc_ff, pcv_ff, val_ff, idx_ff, wr_ff};
endmodule

/* design/rvx_control.sv */
// Controller: sequences capture, operand read, execute and write-back.
module rvx_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                rsp_busy,
   input  rvx_pkg::status_type status,
   output rvx_pkg::cmd_type    cmd,
   output logic                req_ready,
   output logic                rsp_load
);
   rvx_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rvx_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         rvx_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in = rvx_pkg::ST_READ;
            end
         end
         rvx_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = rvx_pkg::ST_EXEC;
         end
         rvx_pkg::ST_EXEC: begin
            if (status.is_mul) begin
               cmd.mul_start = 1'b1;
               state_in = rvx_pkg::ST_MUL;
            end else if (status.is_div) begin
               cmd.div_start = 1'b1;
               state_in = rvx_pkg::ST_DIV;
            end else begin
               state_in = rvx_pkg::ST_DONE;
            end
         end
         rvx_pkg::ST_MUL: begin
            if (status.mul_last) begin
               cmd.mul_fin = 1'b1;
               state_in = rvx_pkg::ST_DONE;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         rvx_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = rvx_pkg::ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         rvx_pkg::ST_DONE: begin
            if (!rsp_busy) begin
               cmd.commit = 1'b1;
               rsp_load = 1'b1;
               state_in = rvx_pkg::ST_IDLE;
            end
         end
         default: state_in = rvx_pkg::ST_IDLE;
      endcase
      cmd.exec = (state_ff == rvx_pkg::ST_EXEC);
      cmd.div_fin = (state_ff == rvx_pkg::ST_DIV) && status.div_last;
   end
endmodule

/* design/rv64im_integer_execute_core.sv */
// RV64IM execute core: one instruction at a time against a 31-entry register
// file. ALU, jump and branch ops pass through capture, operand read, execute
// and write-back states; the multiplier adds a step state (four 32x32 partial
// products through one unit) and the divider adds another (restoring, one
// quotient bit a cycle). The result stays in an output register until
// transferred; the next request is taken once the result has been loaded
// there.
`include "rv64im_integer_execute_core_assert.svh"
module rv64im_integer_execute_core #(
   parameter int unsigned XLEN = rvx_pkg::XLEN_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // cmd[5:0], dest_index[10:6], src1_index[15:11], src2_index[20:16],
   // immediate[52:21], instr_pc[116:53], zero fill above
   input  logic [119:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // write_enable[0], write_index[5:1], write_value[69:6], pc_valid[70],
   // next_pc[134:71], exception[136:135], zero fill above
   output logic [143:0]  rsp_tdata
);
   rvx_pkg::cmd_type    cmd;
   rvx_pkg::status_type status;
   logic req_fire, rsp_load, ready;
   logic rsp_valid_ff;

   assign req_fire   = req_tvalid && ready;
   assign req_tready = ready;

   rvx_control u_ctrl (
      .clock, .reset, .req_fire,
      .rsp_busy(rsp_valid_ff && !rsp_tready),
      .status, .cmd, .req_ready(ready), .rsp_load
   );

   rvx_datapath #(.XLEN(XLEN)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_op(req_tdata[5:0]), .req_rd(req_tdata[10:6]),
      .req_rs1(req_tdata[15:11]), .req_rs2(req_tdata[20:16]),
      .req_imm(req_tdata[52:21]), .req_pc(req_tdata[116:53]),
      .rsp_data(rsp_tdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   assign rsp_tvalid = rsp_valid_ff;

   `RVX_ASSERT_NEXT(a_load_valid, clock, reset, rsp_load, rsp_tvalid)
   `RVX_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_tvalid && !rsp_tready, !rsp_load)
   `RVX_ASSERT_IMP(a_one_op, clock, reset, 1'b1, $onehot0({cmd.mul_start, cmd.div_start}))
endmodule
